/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check an implication in the clock cycle after the antecedent.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/pdflex_pkg.sv */
package pdflex_pkg;

  localparam int MaxTokenLen  = 128;
  localparam int FractionBits = 16;
  localparam int DivCntW      = $clog2(FractionBits + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       at_end;
  } lex_in_t;

  typedef struct packed {
    logic [4:0]         kind;
    logic [7:0]         token_byte;
    logic signed [31:0] number;
    logic               warned;
    logic               last;
  } lex_out_t;

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_INT, M_FRAC, M_STR, M_STR_ESC, M_STR_OCT, M_STR_CR,
    M_LT, M_HEX, M_GT, M_NAME, M_NAME_HASH, M_NAME_HEX2, M_CMD
  } lex_mode_t;

  typedef enum logic [1:0] {
    S_IDLE, S_STEP, S_DIV, S_EMIT
  } seq_state_t;

  localparam logic [4:0] K_INT = 5'd0, K_REAL = 5'd1, K_SBYTE = 5'd2,
    K_SEND = 5'd3, K_NBYTE = 5'd4, K_NEND = 5'd5, K_CBYTE = 5'd6, K_CEND = 5'd7,
    K_TRUE = 5'd8, K_FALSE = 5'd9, K_NULL = 5'd10, K_LBRK = 5'd11,
    K_RBRK = 5'd12, K_LDICT = 5'd13, K_RDICT = 5'd14, K_ERR = 5'd15,
    K_END = 5'd16;

  localparam logic [39:0] KwTrue  = 40'h0074727565;
  localparam logic [39:0] KwFalse = 40'h66616C7365;
  localparam logic [39:0] KwNull  = 40'h006E756C6C;

  function automatic logic [31:0] pow_ten(input logic [3:0] n);
    case (n)
      4'd0: return 32'd1;
      4'd1: return 32'd10;
      4'd2: return 32'd100;
      4'd3: return 32'd1000;
      4'd4: return 32'd10000;
      4'd5: return 32'd100000;
      4'd6: return 32'd1000000;
      4'd7: return 32'd10000000;
      4'd8: return 32'd100000000;
      default: return 32'd1000000000;
    endcase
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c inside {[8'd9:8'd13]}) || c == 8'd32;
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return c inside {8'd9, 8'd10, 8'd13, 8'd32, "%", "(", ")", "/", "<", ">",
                     "[", "]", "{", "}"};
  endfunction

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    // Bit 4 set marks a non-hex byte.
    if (c inside {["0":"9"]}) return {1'b0, 4'(c - "0")};
    if (c inside {["A":"F"]}) return {1'b0, 4'(c - "A" + 8'd10)};
    if (c inside {["a":"f"]}) return {1'b0, 4'(c - "a" + 8'd10)};
    return 5'h10;
  endfunction

endpackage

/* rtl/core/pdflex_frac_div.sv */
module pdflex_frac_div
  import pdflex_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [32:0]        rem;
  logic [31:0]        scale;
  logic [DivCntW-1:0] cnt;
  logic               busy;
  logic [33:0]        shifted;

  assign shifted = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        rem      <= {1'b0, dividend};
        scale    <= divisor;
        quotient <= '0;
        cnt      <= '0;
      end else if (busy) begin
        // One restoring step: shift, compare, subtract.
        if (shifted >= {2'b0, scale}) begin
          rem      <= 33'(shifted - {2'b0, scale});
          quotient <= {quotient[30:0], 1'b1};
        end else begin
          rem      <= shifted[32:0];
          quotient <= {quotient[30:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == DivCntW'(FractionBits - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/pdf_token_lexer_core.sv */
// Byte-serial PDF content tokenizer.
// Flow: an accepted byte is stepped by the lexer in up to four passes (a lookahead byte
// is stepped again); a real close then waits on the fraction divider; the results follow.
// A new byte is taken only after all results of the last byte are shown, or at once when
// it gave none; ready is low while busy.
// Reset (rst, synchronous): lexer idle between tokens, all accumulators zero.
`include "assert_macros.svh"
module pdf_token_lexer_core
  import pdflex_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  lex_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output lex_out_t out_data
);

  // Token state.
  lex_mode_t   mode, mode_next;
  logic [15:0] depth, depth_next;
  logic [31:0] iacc, iacc_next, facc, facc_next;
  logic [3:0]  fdig, fdig_next;
  logic        neg, neg_next;
  logic [7:0]  eacc, eacc_next;
  logic [1:0]  ecnt, ecnt_next;
  logic [7:0]  tlen, tlen_next;
  logic [39:0] kwp, kwp_next;
  logic        warn, warn_next;

  // Sequencer.
  seq_state_t  st, st_next;
  logic [7:0]  cur;
  logic        cur_end;
  logic [2:0]  passes;

  // Result queue for one input word (up to three results), filled by all
  // passes over the word before any result is shown.
  lex_out_t    q [3];
  logic [1:0]  qn, qrd;
  logic [2:0]  qsum;

  // Step outputs.
  lex_out_t    r [3];
  logic [1:0]  rn;
  logic        again, need_div;

  logic        div_start, div_done;
  logic [31:0] div_q;
  logic [31:0] fixed_mag, real_num;

  pdflex_frac_div u_div (
    .clk, .rst, .start(div_start), .dividend(facc), .divisor(pow_ten(fdig)),
    .done(div_done), .quotient(div_q)
  );

  assign in_ready  = (st == S_IDLE);
  assign out_valid = (st == S_EMIT);
  assign qsum      = {1'b0, qn} + {1'b0, rn};

  // Real value: whole part shifted, fraction added, sign applied.
  assign fixed_mag = (iacc << FractionBits) + div_q;
  assign real_num  = neg ? 32'(0 - fixed_mag) : fixed_mag;

  always_comb begin
    out_data      = q[qrd];
    out_data.last = (qrd == qn - 2'd1);
  end

  // One lexer step on the held byte. Emits into r, sets again when
  // the byte must be stepped again. A pending real close defers to divider.
  always_comb begin
    logic [4:0]  h;
    logic        dig, cmd, ovf;
    logic [7:0]  c, ab;
    logic        do_add, do_close_cmd, do_clear;
    logic [4:0]  ckind;
    logic [31:0] ival;
    mode_next = mode; depth_next = depth; iacc_next = iacc; facc_next = facc;
    fdig_next = fdig; neg_next = neg; eacc_next = eacc; ecnt_next = ecnt;
    tlen_next = tlen; kwp_next = kwp; warn_next = warn;
    for (int i = 0; i < 3; i++) r[i] = '0;
    rn = 2'd0; again = 1'b0; need_div = 1'b0;
    c = cur; dig = c inside {["0":"9"]}; h = hex_val(c);
    cmd = 1'b0; ovf = 1'b0;
    do_add = 1'b0; ab = c; do_close_cmd = 1'b0; do_clear = 1'b0;
    ival = neg ? 32'(0 - iacc) : iacc;
    ckind = K_CEND;
    if (tlen == 8'd4 && kwp == KwTrue) ckind = K_TRUE;
    else if (tlen == 8'd5 && kwp == KwFalse) ckind = K_FALSE;
    else if (tlen == 8'd4 && kwp == KwNull) ckind = K_NULL;
    if (cur_end) begin
      case (mode)
        M_INT: begin
          r[0].kind = K_INT; r[0].number = ival; rn = 2'd1;
        end
        M_FRAC: need_div = 1'b1;
        M_STR, M_STR_ESC, M_STR_CR, M_LT: begin
          r[0].kind = K_SEND; r[0].warned = 1'b1; rn = 2'd1;
        end
        M_STR_OCT: begin
          r[0].kind = K_SBYTE; r[0].token_byte = eacc;
          r[1].kind = K_SEND; r[1].warned = 1'b1; rn = 2'd2;
        end
        M_HEX: begin
          if (ecnt == 2'd1) begin
            r[0].kind = K_SBYTE; r[0].token_byte = {eacc[3:0], 4'h0};
            r[1].kind = K_SEND; r[1].warned = 1'b1; rn = 2'd2;
          end else begin
            r[0].kind = K_SEND; r[0].warned = 1'b1; rn = 2'd1;
          end
        end
        M_GT: begin
          r[0].kind = K_ERR; r[0].warned = 1'b1; rn = 2'd1;
        end
        M_NAME: begin
          r[0].kind = K_NEND; r[0].warned = warn; rn = 2'd1;
        end
        M_NAME_HASH, M_NAME_HEX2: begin
          ab = (mode == M_NAME_HASH) ? 8'h23 : {eacc[3:0], 4'h0};
          if (tlen + 9'd1 >= 9'(MaxTokenLen)) begin
            r[0].kind = K_NEND; r[0].warned = 1'b1; rn = 2'd1;
          end else begin
            r[0].kind = K_NBYTE; r[0].token_byte = ab;
            r[1].kind = K_NEND;
            r[1].warned = warn | (mode == M_NAME_HEX2); rn = 2'd2;
          end
        end
        M_CMD: begin
          r[0].kind = ckind; r[0].warned = warn; rn = 2'd1;
        end
        default: ;
      endcase
      if (!need_div) begin
        r[rn].kind = K_END; rn = rn + 2'd1; do_clear = 1'b1;
      end
    end else begin
      case (mode)
        M_COMMENT: if (c == 8'd13 || c == 8'd10) mode_next = M_IDLE;
        M_INT: begin
          if (dig) iacc_next = 32'(iacc * 32'd10) + 32'(c - "0");
          else if (c == ".") mode_next = M_FRAC;
          else begin
            r[0].kind = K_INT; r[0].number = ival; rn = 2'd1;
            do_clear = 1'b1; again = 1'b1;
          end
        end
        M_FRAC: begin
          if (dig) begin
            if (fdig < 4'd9) begin
              facc_next = 32'(facc * 32'd10) + 32'(c - "0");
              fdig_next = fdig + 4'd1;
            end
          end else need_div = 1'b1;
        end
        M_STR: begin
          if (c == 8'd10 || c == 8'd13) begin
            r[0].kind = K_SEND; r[0].warned = 1'b1; rn = 2'd1; do_clear = 1'b1;
          end else if (c == "(") begin
            if (depth != 16'hFFFF) depth_next = depth + 16'd1;
            r[0].kind = K_SBYTE; r[0].token_byte = c; rn = 2'd1;
          end else if (c == ")") begin
            if (depth <= 16'd1) begin
              r[0].kind = K_SEND; r[0].warned = warn; rn = 2'd1; do_clear = 1'b1;
            end else begin
              depth_next = depth - 16'd1;
              r[0].kind = K_SBYTE; r[0].token_byte = c; rn = 2'd1;
            end
          end else if (c == "\\") mode_next = M_STR_ESC;
          else begin
            r[0].kind = K_SBYTE; r[0].token_byte = c; rn = 2'd1;
          end
        end
        M_STR_ESC: begin
          mode_next = M_STR;
          r[0].kind = K_SBYTE; rn = 2'd1;
          case (c)
            "n": r[0].token_byte = 8'd10;
            "r": r[0].token_byte = 8'd13;
            "t": r[0].token_byte = 8'd9;
            "b": r[0].token_byte = 8'd8;
            "f": r[0].token_byte = 8'd12;
            8'd13: begin rn = 2'd0; mode_next = M_STR_CR; end
            8'd10: rn = 2'd0;
            default: begin
              if (c inside {["0":"7"]}) begin
                rn = 2'd0; eacc_next = {5'd0, c[2:0]}; ecnt_next = 2'd1;
                mode_next = M_STR_OCT;
              end else r[0].token_byte = c;
            end
          endcase
        end
        M_STR_OCT: begin
          if (c inside {["0":"7"]}) begin
            eacc_next = {eacc[4:0], c[2:0]};
            ecnt_next = ecnt + 2'd1;
            if (ecnt == 2'd2) begin
              r[0].kind = K_SBYTE; r[0].token_byte = {eacc[4:0], c[2:0]};
              rn = 2'd1; ecnt_next = 2'd0; mode_next = M_STR;
            end
          end else begin
            r[0].kind = K_SBYTE; r[0].token_byte = eacc; rn = 2'd1;
            ecnt_next = 2'd0; mode_next = M_STR; again = 1'b1;
          end
        end
        M_STR_CR: begin
          mode_next = M_STR; again = (c != 8'd10);
        end
        M_LT: begin
          if (c == "<") begin
            r[0].kind = K_LDICT; rn = 2'd1; do_clear = 1'b1;
          end else begin
            mode_next = M_HEX; again = 1'b1;
          end
        end
        M_HEX: begin
          if (c == ">") begin
            if (ecnt == 2'd1) begin
              r[0].kind = K_SBYTE; r[0].token_byte = {eacc[3:0], 4'h0};
              r[1].kind = K_SEND; r[1].warned = warn; rn = 2'd2;
            end else begin
              r[0].kind = K_SEND; r[0].warned = warn; rn = 2'd1;
            end
            do_clear = 1'b1;
          end else if (!is_ws(c)) begin
            if (h[4]) warn_next = 1'b1;
            if (ecnt == 2'd0) begin
              eacc_next = {4'd0, h[4] ? 4'd0 : h[3:0]}; ecnt_next = 2'd1;
            end else begin
              r[0].kind = K_SBYTE; r[0].token_byte = {eacc[3:0], h[4] ? 4'd0 : h[3:0]};
              rn = 2'd1; ecnt_next = 2'd0;
            end
          end
        end
        M_GT: begin
          if (c == ">") begin
            r[0].kind = K_RDICT; rn = 2'd1; do_clear = 1'b1;
          end else begin
            r[0].kind = K_ERR; r[0].warned = 1'b1; rn = 2'd1;
            do_clear = 1'b1; again = 1'b1;
          end
        end
        M_NAME: begin
          if (is_delim(c)) begin
            r[0].kind = K_NEND; r[0].warned = warn; rn = 2'd1;
            do_clear = 1'b1; again = 1'b1;
          end else if (c == "#") mode_next = M_NAME_HASH;
          else do_add = 1'b1;
        end
        M_NAME_HASH: begin
          if (!h[4]) begin
            eacc_next = {4'd0, h[3:0]}; mode_next = M_NAME_HEX2;
          end else begin
            mode_next = M_NAME; ab = 8'h23; do_add = 1'b1; again = 1'b1;
          end
        end
        M_NAME_HEX2: begin
          mode_next = M_NAME;
          ab = {eacc[3:0], h[4] ? 4'd0 : h[3:0]};
          if (h[4]) warn_next = 1'b1;
          do_add = 1'b1;
        end
        M_CMD: begin
          if (is_delim(c)) begin
            do_close_cmd = 1'b1; again = 1'b1;
          end else do_add = 1'b1;
        end
        default: begin
          mode_next = M_IDLE;
          if (!is_ws(c)) begin
            case (c)
              "%": mode_next = M_COMMENT;
              "-": begin mode_next = M_INT; neg_next = 1'b1; end
              ".": mode_next = M_FRAC;
              "(": begin mode_next = M_STR; depth_next = 16'd1; end
              "/": mode_next = M_NAME;
              "[": begin r[0].kind = K_LBRK; rn = 2'd1; end
              "]": begin r[0].kind = K_RBRK; rn = 2'd1; end
              "<": mode_next = M_LT;
              ">": mode_next = M_GT;
              ")", "{", "}": begin r[0].kind = K_ERR; rn = 2'd1; end
              default: begin
                if (dig) begin
                  mode_next = M_INT; iacc_next = 32'(c - "0");
                end else begin
                  mode_next = M_CMD; do_add = 1'b1;
                end
              end
            endcase
          end
        end
      endcase
      // Append a byte to a name or command, closing it on overflow.
      if (do_add) begin
        cmd = (mode_next == M_CMD);
        ovf = (tlen + 9'd1 >= 9'(MaxTokenLen));
        if (ovf) begin
          if (cmd) begin
            do_close_cmd = 1'b1; warn_next = 1'b1;
          end else begin
            r[rn].kind = K_NEND; r[rn].warned = 1'b1; rn = rn + 2'd1;
            do_clear = 1'b1;
          end
        end else begin
          r[rn].kind = cmd ? K_CBYTE : K_NBYTE; r[rn].token_byte = ab;
          rn = rn + 2'd1;
          if (tlen < 8'd5) kwp_next = {kwp[31:0], ab};
          tlen_next = tlen + 8'd1;
        end
      end
      if (do_close_cmd) begin
        r[rn].kind = ckind; r[rn].warned = warn_next; rn = rn + 2'd1;
        do_clear = 1'b1;
      end
    end
    if (do_clear) begin
      mode_next = M_IDLE; depth_next = '0; iacc_next = '0; facc_next = '0;
      fdig_next = '0; neg_next = 1'b0; eacc_next = '0; ecnt_next = '0;
      tlen_next = '0; kwp_next = '0; warn_next = 1'b0;
    end
  end

  // Next state of the sequencer. Step the word again while the lexer asks
  // for it (at most four passes), wait on the divider for a real, then show any results.
  always_comb begin
    st_next = st;
    case (st)
      S_IDLE: if (in_valid) st_next = S_STEP;
      S_STEP: begin
        if (need_div) st_next = S_DIV;
        else if (again && passes != 3'd3) st_next = S_STEP;
        else if (qsum != 3'd0) st_next = S_EMIT;
        else st_next = S_IDLE;
      end
      S_DIV: if (div_done) st_next = cur_end ? S_EMIT : S_STEP;
      S_EMIT: begin
        if (out_ready && qrd == qn - 2'd1) st_next = S_IDLE;
      end
      default: st_next = S_IDLE;
    endcase
  end

  assign div_start = (st == S_STEP) && need_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; mode <= M_IDLE; depth <= '0; iacc <= '0; facc <= '0;
      fdig <= '0; neg <= 1'b0; eacc <= '0; ecnt <= '0; tlen <= '0;
      kwp <= '0; warn <= 1'b0; qn <= '0; qrd <= '0; passes <= '0;
    end else begin
      st <= st_next;
      case (st)
        S_IDLE: if (in_valid) begin
          cur <= in_data.data_byte; cur_end <= in_data.at_end; passes <= '0;
          qn <= '0; qrd <= '0;
        end
        S_STEP: begin
          passes <= passes + 3'd1;
          if (!need_div) begin
            mode <= mode_next; depth <= depth_next; iacc <= iacc_next;
            facc <= facc_next; fdig <= fdig_next; neg <= neg_next;
            eacc <= eacc_next; ecnt <= ecnt_next; tlen <= tlen_next;
            kwp <= kwp_next; warn <= warn_next;
            // Append this pass's results behind those of earlier passes.
            for (int i = 0; i < 3; i++) begin
              if (3'(i) < {1'b0, rn} && {1'b0, qn} + 3'(i) < 3'd3)
                q[2'({1'b0, qn} + 3'(i))] <= r[i];
            end
            qn <= (qsum > 3'd3) ? 2'd3 : qsum[1:0];
          end
        end
        S_DIV: if (div_done) begin
          q[0] <= '{kind: K_REAL, token_byte: 8'd0, number: real_num,
                    warned: 1'b0, last: 1'b0};
          if (cur_end)
            q[1] <= '{kind: K_END, token_byte: 8'd0, number: 32'd0,
                      warned: 1'b0, last: 1'b0};
          qn <= cur_end ? 2'd2 : 2'd1;
          mode <= M_IDLE; iacc <= '0; facc <= '0; fdig <= '0; neg <= 1'b0;
          eacc <= '0; ecnt <= '0; tlen <= '0; kwp <= '0; warn <= 1'b0;
          depth <= '0;
        end
        S_EMIT: if (out_ready) qrd <= qrd + 2'd1;
        default: ;
      endcase
    end
  end

  `CHK_IMPL(a_no_accept_busy, clk, rst, st != S_IDLE, !in_ready,
            "input accepted while busy")
  `CHK_NEXT(a_div_start, clk, rst, div_start, st == S_DIV,
            "divider started outside a real close")
  `CHK_IMPL(a_emit_nonempty, clk, rst, out_valid, qn != 2'd0,
            "result shown with empty queue")

endmodule

/* verif/tb_pdf_token_lexer_core.sv */
`timescale 1ns / 100ps
module tb_pdf_token_lexer_core;
  import pdflex_pkg::*;

  localparam int StallLimit = 5000;
  localparam int HoldCycles = 300;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  lex_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  lex_out_t out_data;

  always #5 clk = ~clk;

  pdf_token_lexer_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Tokens still owed by the lexer, oldest first, and scratch for one word.
  lex_out_t token_q[$];
  lex_out_t word_toks[$];

  int n_words, n_tokens, n_errors, idle_cycles, burst_left;
  bit hold_req;

  // Shadow lexer state.
  lex_mode_t   sh_mode;
  logic [15:0] sh_depth;
  logic [31:0] sh_int, sh_frac;
  logic [3:0]  sh_fdig;
  logic        sh_neg;
  logic [7:0]  sh_esc;
  logic [1:0]  sh_ecnt;
  logic [7:0]  sh_len;
  logic [39:0] sh_kw;
  logic        sh_warn;

  function automatic bit white(input logic [7:0] c);
    return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
  endfunction

  function automatic bit breaks_token(input logic [7:0] c);
    return c == 8'd9 || c == 8'd10 || c == 8'd13 || c == 8'd32 || c == "%" ||
           c == "(" || c == ")" || c == "/" || c == "<" || c == ">" ||
           c == "[" || c == "]" || c == "{" || c == "}";
  endfunction

  // Nibble value, -1 for a non-hex byte.
  function automatic int nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return -1;
  endfunction

  function automatic void clear_shadow();
    sh_mode = M_IDLE; sh_depth = '0; sh_int = '0; sh_frac = '0; sh_fdig = '0;
    sh_neg = 1'b0; sh_esc = '0; sh_ecnt = '0; sh_len = '0; sh_kw = '0;
    sh_warn = 1'b0;
  endfunction

  function automatic void give(input logic [4:0] k, input logic [7:0] b,
                               input logic [31:0] n, input logic w);
    lex_out_t r;
    if (word_toks.size() < 3) begin
      r.kind = k; r.token_byte = b; r.number = n; r.warned = w; r.last = 1'b0;
      word_toks.push_back(r);
    end
  endfunction

  function automatic logic [31:0] int_result();
    return sh_neg ? -sh_int : sh_int;
  endfunction

  // Real value: fraction by restoring division against 10^digits, whole part and sign added.
  function automatic logic [31:0] fixed_result();
    logic [63:0] rem, scale;
    logic [31:0] q, v;
    scale = 64'd1;
    for (int i = 0; i < int'(sh_fdig) && i < 9; i++) scale = scale * 10;
    rem = {32'd0, sh_frac};
    q = '0;
    for (int i = 0; i < FractionBits; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= scale) begin
        rem = rem - scale;
        q[0] = 1'b1;
      end
    end
    v = (sh_int << FractionBits) + q;
    return sh_neg ? -v : v;
  endfunction

  function automatic void close_with(input logic [4:0] k);
    give(k, 8'd0, 32'd0, sh_warn);
    clear_shadow();
  endfunction

  function automatic void close_command();
    logic [4:0] k;
    k = K_CEND;
    if (sh_len == 8'd4 && sh_kw == KwTrue) k = K_TRUE;
    else if (sh_len == 8'd5 && sh_kw == KwFalse) k = K_FALSE;
    else if (sh_len == 8'd4 && sh_kw == KwNull) k = K_NULL;
    close_with(k);
  endfunction

  function automatic void append(input logic [7:0] c);
    bit is_cmd;
    is_cmd = (sh_mode == M_CMD);
    // Drop the byte that would overflow and end the token flagged.
    if (int'(sh_len) + 1 >= MaxTokenLen) begin
      sh_warn = 1'b1;
      if (is_cmd) close_command(); else close_with(K_NEND);
      return;
    end
    give(is_cmd ? K_CBYTE : K_NBYTE, c, 32'd0, 1'b0);
    if (sh_len < 8'd5) sh_kw = {sh_kw[31:0], c};
    sh_len = sh_len + 8'd1;
  endfunction

  function automatic void hex_close();
    if (sh_ecnt == 2'd1) give(K_SBYTE, {sh_esc[3:0], 4'h0}, 32'd0, 1'b0);
    close_with(K_SEND);
  endfunction

  function automatic void open_token(input logic [7:0] c);
    if (white(c)) return;
    case (c)
      "%": sh_mode = M_COMMENT;
      "-": begin sh_mode = M_INT; sh_neg = 1'b1; end
      ".": sh_mode = M_FRAC;
      "(": begin sh_mode = M_STR; sh_depth = 16'd1; end
      "/": sh_mode = M_NAME;
      "[": give(K_LBRK, 8'd0, 32'd0, 1'b0);
      "]": give(K_RBRK, 8'd0, 32'd0, 1'b0);
      "<": sh_mode = M_LT;
      ">": sh_mode = M_GT;
      ")", "{", "}": give(K_ERR, 8'd0, 32'd0, 1'b0);
      default: begin
        if (c >= "0" && c <= "9") begin
          sh_mode = M_INT;
          sh_int = 32'(c - "0");
        end else begin
          sh_mode = M_CMD;
          append(c);
        end
      end
    endcase
  endfunction

  // One pass over a byte; returns 1 when the byte must be looked at again.
  function automatic bit lex_byte(input logic [7:0] c);
    int h;
    bit digit;
    digit = (c >= "0" && c <= "9");
    case (sh_mode)
      M_COMMENT: begin
        if (c == 8'd13 || c == 8'd10) sh_mode = M_IDLE;
        return 0;
      end
      M_INT: begin
        if (digit) begin sh_int = sh_int * 10 + 32'(c - "0"); return 0; end
        if (c == ".") begin sh_mode = M_FRAC; return 0; end
        give(K_INT, 8'd0, int_result(), 1'b0);
        clear_shadow();
        return 1;
      end
      M_FRAC: begin
        if (digit) begin
          if (sh_fdig < 4'd9) begin
            sh_frac = sh_frac * 10 + 32'(c - "0");
            sh_fdig = sh_fdig + 4'd1;
          end
          return 0;
        end
        give(K_REAL, 8'd0, fixed_result(), 1'b0);
        clear_shadow();
        return 1;
      end
      M_STR: begin
        if (c == 8'd10 || c == 8'd13) begin sh_warn = 1'b1; close_with(K_SEND); end
        else if (c == "(") begin
          if (sh_depth != 16'hFFFF) sh_depth = sh_depth + 16'd1;
          give(K_SBYTE, c, 32'd0, 1'b0);
        end else if (c == ")") begin
          if (sh_depth <= 16'd1) close_with(K_SEND);
          else begin sh_depth = sh_depth - 16'd1; give(K_SBYTE, c, 32'd0, 1'b0); end
        end else if (c == "\\") sh_mode = M_STR_ESC;
        else give(K_SBYTE, c, 32'd0, 1'b0);
        return 0;
      end
      M_STR_ESC: begin
        sh_mode = M_STR;
        case (c)
          "n": give(K_SBYTE, 8'd10, 32'd0, 1'b0);
          "r": give(K_SBYTE, 8'd13, 32'd0, 1'b0);
          "t": give(K_SBYTE, 8'd9, 32'd0, 1'b0);
          "b": give(K_SBYTE, 8'd8, 32'd0, 1'b0);
          "f": give(K_SBYTE, 8'd12, 32'd0, 1'b0);
          8'd13: sh_mode = M_STR_CR;
          8'd10: ;
          default: begin
            if (c >= "0" && c <= "7") begin
              sh_esc = {5'd0, c[2:0]};
              sh_ecnt = 2'd1;
              sh_mode = M_STR_OCT;
            end else give(K_SBYTE, c, 32'd0, 1'b0);
          end
        endcase
        return 0;
      end
      M_STR_OCT: begin
        if (c >= "0" && c <= "7") begin
          sh_esc = {sh_esc[4:0], c[2:0]};
          sh_ecnt = sh_ecnt + 2'd1;
          if (sh_ecnt == 2'd3) begin
            give(K_SBYTE, sh_esc, 32'd0, 1'b0);
            sh_ecnt = '0;
            sh_mode = M_STR;
          end
          return 0;
        end
        give(K_SBYTE, sh_esc, 32'd0, 1'b0);
        sh_ecnt = '0;
        sh_mode = M_STR;
        return 1;
      end
      M_STR_CR: begin
        sh_mode = M_STR;
        return c != 8'd10;
      end
      M_LT: begin
        if (c == "<") begin give(K_LDICT, 8'd0, 32'd0, 1'b0); clear_shadow(); return 0; end
        sh_mode = M_HEX;
        return 1;
      end
      M_HEX: begin
        if (c == ">") begin hex_close(); return 0; end
        if (white(c)) return 0;
        h = nibble(c);
        if (h < 0) begin sh_warn = 1'b1; h = 0; end
        if (sh_ecnt == 2'd0) begin
          sh_esc = 8'(h);
          sh_ecnt = 2'd1;
        end else begin
          give(K_SBYTE, {sh_esc[3:0], 4'(h)}, 32'd0, 1'b0);
          sh_ecnt = '0;
        end
        return 0;
      end
      M_GT: begin
        if (c == ">") begin give(K_RDICT, 8'd0, 32'd0, 1'b0); clear_shadow(); return 0; end
        give(K_ERR, 8'd0, 32'd0, 1'b1);
        clear_shadow();
        return 1;
      end
      M_NAME: begin
        if (breaks_token(c)) begin close_with(K_NEND); return 1; end
        if (c == "#") begin sh_mode = M_NAME_HASH; return 0; end
        append(c);
        return 0;
      end
      M_NAME_HASH: begin
        h = nibble(c);
        if (h >= 0) begin
          sh_esc = 8'(h);
          sh_mode = M_NAME_HEX2;
          return 0;
        end
        sh_mode = M_NAME;
        append("#");
        return 1;
      end
      M_NAME_HEX2: begin
        h = nibble(c);
        if (h < 0) begin sh_warn = 1'b1; h = 0; end
        sh_mode = M_NAME;
        append({sh_esc[3:0], 4'(h)});
        return 0;
      end
      M_CMD: begin
        if (breaks_token(c)) begin close_command(); return 1; end
        append(c);
        return 0;
      end
      default: begin
        sh_mode = M_IDLE;
        open_token(c);
        return 0;
      end
    endcase
  endfunction

  // Close whatever is pending at end of input, then mark the end.
  function automatic void flush_shadow();
    case (sh_mode)
      M_INT: give(K_INT, 8'd0, int_result(), 1'b0);
      M_FRAC: give(K_REAL, 8'd0, fixed_result(), 1'b0);
      M_STR, M_STR_ESC, M_STR_CR, M_LT: begin sh_warn = 1'b1; close_with(K_SEND); end
      M_STR_OCT: begin
        give(K_SBYTE, sh_esc, 32'd0, 1'b0);
        sh_warn = 1'b1;
        close_with(K_SEND);
      end
      M_HEX: begin sh_warn = 1'b1; hex_close(); end
      M_GT: give(K_ERR, 8'd0, 32'd0, 1'b1);
      M_NAME: close_with(K_NEND);
      M_NAME_HASH: begin
        sh_mode = M_NAME;
        append("#");
        if (sh_mode == M_NAME) close_with(K_NEND);
      end
      M_NAME_HEX2: begin
        sh_warn = 1'b1;
        sh_mode = M_NAME;
        append({sh_esc[3:0], 4'h0});
        if (sh_mode == M_NAME) close_with(K_NEND);
      end
      M_CMD: close_command();
      default: ;
    endcase
    clear_shadow();
    give(K_END, 8'd0, 32'd0, 1'b0);
  endfunction

  // Work out the tokens one accepted word causes and queue them.
  function automatic void predict_tokens(input lex_in_t w);
    word_toks.delete();
    if (w.at_end) flush_shadow();
    else for (int i = 0; i < 4; i++) if (!lex_byte(w.data_byte)) break;
    if (word_toks.size() > 0) word_toks[word_toks.size() - 1].last = 1'b1;
    foreach (word_toks[i]) token_q.push_back(word_toks[i]);
  endfunction

  // Drive one word; the sender may idle between bursts of random length.
  task automatic send_word(input logic [7:0] b, input logic e);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, at_end: e};
    do @(posedge clk); while (!in_ready);
    predict_tokens('{data_byte: b, at_end: e});
    n_words++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic send_end();
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Receiver: stall on a pattern that is redrawn for each run of random length,
  // or hold off entirely when asked.
  initial begin
    int pct, left;
    pct = 100;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end
      if (left == 0) begin
        left = $urandom_range(10, 60);
        case ($urandom_range(0, 3))
          0: pct = 100;
          1: pct = 70;
          2: pct = 40;
          default: pct = 10;
        endcase
      end
      left--;
      out_ready <= ($urandom_range(1, 100) <= pct);
    end
  end

  // Compare every accepted token with the oldest one still owed.
  always @(posedge clk) begin
    lex_out_t want;
    if (!rst && out_valid && out_ready) begin
      n_tokens++;
      if (token_q.size() == 0) begin
        n_errors++;
        $display("%0t unexpected token: kind %0d byte %0h number %0h warned %0b last %0b",
                 $time, out_data.kind, out_data.token_byte, out_data.number,
                 out_data.warned, out_data.last);
      end else begin
        want = token_q.pop_front();
        if (out_data.kind !== want.kind) begin
          n_errors++;
          $display("%0t kind: expected %0d, got %0d", $time, want.kind, out_data.kind);
        end
        if (out_data.token_byte !== want.token_byte) begin
          n_errors++;
          $display("%0t token_byte: expected %0h, got %0h", $time, want.token_byte,
                   out_data.token_byte);
        end
        if (out_data.number !== want.number) begin
          n_errors++;
          $display("%0t number: expected %0h, got %0h", $time, want.number,
                   out_data.number);
        end
        if (out_data.warned !== want.warned) begin
          n_errors++;
          $display("%0t warned: expected %0b, got %0b", $time, want.warned,
                   out_data.warned);
        end
        if (out_data.last !== want.last) begin
          n_errors++;
          $display("%0t last: expected %0b, got %0b", $time, want.last, out_data.last);
        end
      end
    end
  end

  // Watchdog: too long with no word moving on either side ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("%0t timeout with %0d tokens owed", $time, token_q.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_numbers();
    // Wrap, lone sign and point, long fractions.
    send_text("4294967297 - . -.5 1.123456789012 99");
    send_word(8'd10, 1'b0);
  endtask

  task automatic test_literal_strings();
    send_text("(a(b)\\n\\)\\777\\7x\\0123\\q");
    send_text({"\\", 8'd13, 8'd10, "p\\", 8'd13, "q\\", 8'd10, "z)"});
    send_text({"(r", 8'd10, "(c", 8'd13, " "});
  endtask

  task automatic test_hex_strings();
    send_text({"<4a", 8'd9, "6F7> <> <4g> ", "<9", 8'd12, "z>"});
  endtask

  task automatic test_names();
    send_text("/A#41#4g#zz/ /# /x#(");
    send_text(") ");
  endtask

  task automatic test_keywords_marks();
    send_text("true false null nul [ ] << >> ) { } >a {");
    send_text("% c (x)");
    send_text({8'd13, "Tj", 8'd0, 8'hFF, " "});
  endtask

  // A name one byte too long: the byte that overflows is dropped.
  task automatic test_overflow();
    send_word("/", 1'b0);
    repeat (MaxTokenLen) send_word("a", 1'b0);
    send_word(" ", 1'b0);
  endtask

  task automatic test_end_of_input();
    send_text("(abc");  send_end();
    send_text("(\\12"); send_end();
    send_text("(\\");   send_end();
    send_text("<4");    send_end();
    send_text("<");     send_end();
    send_text(">");     send_end();
    send_text("/x#");   send_end();
    send_text("/x#4");  send_end();
    send_text("12");    send_end();
    send_text("-1.5");  send_end();
    send_text("false"); send_end();
    send_end();
  endtask

  // Receiver holds off while the sender keeps pushing brackets.
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (12) send_text("[");
  endtask

  // Random, mostly well-formed tokens with random content.
  task automatic test_random_stream(input int target);
    byte unsigned tk[$];
    int sent, n, depth;
    string marks[8];
    string words[6];
    marks = '{"[", "]", "<<", ">>", ")", "{", "}", ">q"};
    words = '{"true", "false", "null", "BT", "re", "Tf"};
    sent = 0;
    while (sent < target) begin
      tk.delete();
      case ($urandom_range(0, 19))
        0, 1: begin
          if ($urandom_range(0, 2) == 0) tk.push_back("-");
          repeat ($urandom_range(1, 12)) tk.push_back(8'("0" + $urandom_range(0, 9)));
        end
        2, 3: begin
          if ($urandom_range(0, 2) == 0) tk.push_back("-");
          repeat ($urandom_range(0, 6)) tk.push_back(8'("0" + $urandom_range(0, 9)));
          tk.push_back(".");
          repeat ($urandom_range(0, 12)) tk.push_back(8'("0" + $urandom_range(0, 9)));
        end
        4, 5, 6: begin
          tk.push_back("(");
          depth = 0;
          repeat ($urandom_range(0, 10)) begin
            case ($urandom_range(0, 9))
              0: begin tk.push_back("("); depth++; end
              1: if (depth > 0) begin tk.push_back(")"); depth--; end
              2: begin
                tk.push_back("\\");
                n = $urandom_range(0, 7);
                case (n)
                  0: tk.push_back("n");
                  1: tk.push_back(8'($urandom_range(0, 1) ? 13 : 10));
                  2: repeat ($urandom_range(1, 3)) tk.push_back(8'("0" + $urandom_range(0, 7)));
                  3: tk.push_back(8'($urandom_range(0, 255)));
                  4: tk.push_back("t");
                  5: tk.push_back("f");
                  6: tk.push_back("b");
                  default: tk.push_back("r");
                endcase
              end
              3: if ($urandom_range(0, 3) == 0) tk.push_back(8'($urandom_range(0, 1) ? 13 : 10));
              default: tk.push_back(8'($urandom_range(128, 255) - ($urandom_range(0, 1) * 96)));
            endcase
          end
          repeat (depth + 1) tk.push_back(")");
        end
        7, 8: begin
          tk.push_back("<");
          repeat ($urandom_range(0, 7)) begin
            case ($urandom_range(0, 7))
              0: tk.push_back(" ");
              1: tk.push_back("x");
              2: tk.push_back(8'("a" + $urandom_range(0, 5)));
              default: tk.push_back(8'("0" + $urandom_range(0, 9)));
            endcase
          end
          tk.push_back(">");
        end
        9, 10, 11: begin
          tk.push_back("/");
          repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 5))
              0: begin tk.push_back("#"); tk.push_back("4"); tk.push_back("F"); end
              1: begin tk.push_back("#"); tk.push_back(8'($urandom_range(0, 1) ? "z" : "2")); end
              default: tk.push_back(8'("A" + $urandom_range(0, 25)));
            endcase
          end
        end
        12, 13: begin
          n = $urandom_range(0, 5);
          for (int i = 0; i < words[n].len(); i++) tk.push_back(words[n][i]);
        end
        14, 15: begin
          n = $urandom_range(0, 7);
          for (int i = 0; i < marks[n].len(); i++) tk.push_back(marks[n][i]);
        end
        16: begin
          tk.push_back("%");
          repeat ($urandom_range(0, 5)) tk.push_back(8'($urandom_range(32, 255)));
          tk.push_back(8'($urandom_range(0, 1) ? 13 : 10));
        end
        17, 18: tk.push_back(8'($urandom_range(0, 255)));
        default: ;
      endcase
      foreach (tk[i]) send_word(tk[i], 1'b0);
      sent += tk.size();
      case ($urandom_range(0, 5))
        0: ;
        1: send_word(8'd10, 1'b0);
        2: send_word(8'($urandom_range(9, 13)), 1'b0);
        default: send_word(" ", 1'b0);
      endcase
      sent++;
      if ($urandom_range(0, 29) == 0) begin send_end(); sent++; end
    end
    send_end();
  endtask

  initial begin
    clear_shadow();
    n_words = 0; n_tokens = 0; n_errors = 0; idle_cycles = 0; burst_left = 0;
    hold_req = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_numbers();
    test_literal_strings();
    test_hex_strings();
    test_names();
    test_keywords_marks();
    test_overflow();
    test_end_of_input();
    test_backpressure();
    test_random_stream(24);

    in_valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("lexer run: %0d words sent, %0d tokens checked, %0d mismatches",
             n_words, n_tokens, n_errors);
    $display("covered numbers, strings, hex, names, keywords, marks, overflow, end of input");
    if (n_errors == 0 && token_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
